// File: design/stm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_pkg
// Shared types, field widths, request and status codes for the sparse table
// range maximum block.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVELS_DEF       = 11;
  localparam int DATA_WIDTH_DEF   = 32;

  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int RANGE_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
    logic [RANGE_W-1:0]        range_begin;
    logic [RANGE_W-1:0]        range_end;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic [STATUS_W-1:0]       status;
  } rsp_t;

endpackage

// File: design/stm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_ram
// Generic simple dual port ram: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module stm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/stm_qdec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_qdec
// Query decode: range checks, window level and the two window start indexes.
// ----------------------------------------------------------------------------
module stm_qdec import stm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int LEVELS       = LEVELS_DEF,
  localparam int IDX_W = $clog2(MAX_ELEMENTS),
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int LVL_W = $clog2(LEVELS)
) (
  input  logic [RANGE_W-1:0]  range_begin,
  input  logic [RANGE_W-1:0]  range_end,
  input  logic [CNT_W-1:0]    count,
  output logic [STATUS_W-1:0] q_status,
  output logic [LVL_W-1:0]    q_lvl,
  output logic [IDX_W-1:0]    q_first,
  output logic [IDX_W-1:0]    q_second
);

  localparam int LEN_W = RANGE_W + 1;
  localparam int LG_W  = $clog2(LEN_W);
  localparam int CW    = (RANGE_W > CNT_W) ? RANGE_W : CNT_W;

  logic [LEN_W-1:0] len;
  logic [LG_W-1:0]  lg;
  logic [LEN_W-1:0] pow;
  logic [LEN_W-1:0] second;

  assign len = LEN_W'(range_end) - LEN_W'(range_begin) + LEN_W'(1);

  // floor log2 of the range length
  always_comb begin
    lg = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (len[i]) begin
        lg = LG_W'(i);
      end
    end
  end

  always_comb begin
    if (int'(lg) > LEVELS - 1) begin
      q_lvl = LVL_W'(LEVELS - 1);
    end else begin
      q_lvl = LVL_W'(lg);
    end
  end

  assign pow      = LEN_W'(1) << q_lvl;
  assign second   = LEN_W'(range_end) + LEN_W'(1) - pow;
  assign q_first  = IDX_W'(range_begin);
  assign q_second = IDX_W'(second);

  always_comb begin
    if (range_begin > range_end) begin
      q_status = ST_EMPTY;
    end else if (CW'(range_end) >= CW'(count)) begin
      q_status = ST_RANGE;
    end else begin
      q_status = ST_OK;
    end
  end

endmodule

// File: design/stm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_ctrl
// Request sequencer: holds the fill count, walks the window levels of an
// append through the table memory and runs the two reads of a query.
// ----------------------------------------------------------------------------
module stm_ctrl import stm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int LEVELS       = LEVELS_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  localparam int IDX_W  = $clog2(MAX_ELEMENTS),
  localparam int LVL_W  = $clog2(LEVELS),
  localparam int ADDR_W = LVL_W + IDX_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  in_data,
  output logic                  out_valid,
  output rsp_t                  out_data,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [ADDR_W-1:0]     rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int SW    = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND,
    S_QRD2,
    S_QMAX
  } state_t;

  state_t                        state_r, state_nxt;
  req_t                          req_r, req_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [LVL_W-1:0]              k_r, k_nxt;
  logic signed [DATA_WIDTH-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]              sec_r, sec_nxt;
  logic [LVL_W-1:0]              qlvl_r, qlvl_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rsp_t                          out_data_r, out_data_nxt;

  logic [STATUS_W-1:0]           q_status;
  logic [LVL_W-1:0]              q_lvl;
  logic [IDX_W-1:0]              q_first;
  logic [IDX_W-1:0]              q_second;

  logic signed [DATA_WIDTH-1:0]  value_w;
  logic signed [DATA_WIDTH-1:0]  rd_s;
  logic signed [DATA_WIDTH-1:0]  mx;
  logic [SW-1:0]                 np1;
  logic [LVL_W:0]                kn;
  logic [SW-1:0]                 pow_k;
  logic [SW-1:0]                 pow_kn;

  stm_qdec #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_qdec (
    .range_begin (req_r.range_begin),
    .range_end   (req_r.range_end),
    .count       (count_r),
    .q_status    (q_status),
    .q_lvl       (q_lvl),
    .q_first     (q_first),
    .q_second    (q_second)
  );

  assign value_w = DATA_WIDTH'(req_r.value);
  assign rd_s    = $signed(rd_data);
  assign mx      = (rd_s > cur_r) ? rd_s : cur_r;
  assign np1     = SW'(idx_r) + SW'(1);
  assign kn      = (LVL_W + 1)'(k_r) + (LVL_W + 1)'(1);
  assign pow_k   = SW'(1) << k_r;
  assign pow_kn  = SW'(1) << kn;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    sec_nxt       = sec_r;
    qlvl_nxt      = qlvl_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_data_nxt.max_value = '0;
        out_data_nxt.status    = ST_OK;
        state_nxt              = S_IDLE;
        out_valid_nxt          = 1'b1;
        case (req_r.req_type)
          REQ_CLEAR: begin
            count_nxt = '0;
          end
          REQ_APPEND: begin
            if (count_r == CNT_W'(MAX_ELEMENTS)) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = {LVL_W'(0), IDX_W'(count_r)};
              wr_data   = value_w;
              cur_nxt   = value_w;
              idx_nxt   = IDX_W'(count_r);
              count_nxt = count_r + CNT_W'(1);
              // level one window ending here starts one element back
              if (count_r != '0) begin
                rd_en         = 1'b1;
                rd_addr       = {LVL_W'(0), IDX_W'(count_r - CNT_W'(1))};
                k_nxt         = LVL_W'(1);
                state_nxt     = S_APPEND;
                out_valid_nxt = 1'b0;
              end
            end
          end
          REQ_QUERY: begin
            if (q_status != ST_OK) begin
              out_data_nxt.status = q_status;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = {q_lvl, q_first};
              sec_nxt       = q_second;
              qlvl_nxt      = q_lvl;
              state_nxt     = S_QRD2;
              out_valid_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // rd_data is the left half of the level k window, cur_r the right half
      S_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = {k_r, IDX_W'(np1 - pow_k)};
        wr_data = mx;
        cur_nxt = mx;
        if ((int'(kn) < LEVELS) && (pow_kn <= np1)) begin
          rd_en   = 1'b1;
          rd_addr = {k_r, IDX_W'(np1 - pow_kn)};
          k_nxt   = LVL_W'(kn);
        end else begin
          out_data_nxt.max_value = '0;
          out_data_nxt.status    = ST_OK;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      S_QRD2: begin
        rd_en     = 1'b1;
        rd_addr   = {qlvl_r, sec_r};
        cur_nxt   = rd_s;
        state_nxt = S_QMAX;
      end

      S_QMAX: begin
        out_data_nxt.max_value = VALUE_W'(mx);
        out_data_nxt.status    = ST_OK;
        out_valid_nxt          = 1'b1;
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
    sec_r      <= sec_nxt;
    qlvl_r     <= qlvl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/sparse_table_range_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_max
// Sparse table for range maximum queries over appended signed values.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its single result
// shows on out_data for exactly one cycle with out_valid high, in the cycle
// busy drops. The receiver cannot hold results off. The next item can be
// taken at the edge that ends that cycle. Clear, rejected and unused requests
// finish in S_EXEC. A query that reads the table passes through S_EXEC and
// S_QRD2, the two reads of the single read port, then S_QMAX for the compare.
// An append of element n walks the window levels above level 0 through the
// table memory in S_APPEND, up to level min(floor(log2(n+1)), LEVELS-1). The
// table memory needs no clearing after reset: a query only reads entries
// written since the last clear.
module sparse_table_range_max import stm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int LEVELS       = LEVELS_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_data,
  output logic out_valid,
  output rsp_t out_data
);

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int ADDR_W = LVL_W + IDX_W;
  localparam int DEPTH  = LEVELS * (2 ** IDX_W);

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  stm_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // window table, level in the upper address bits
  stm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: design/stm_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_chk
// Port level checks for the sparse table range maximum block.
// ----------------------------------------------------------------------------
module stm_chk import stm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input req_t in_data,
  input logic out_valid,
  input rsp_t out_data
);

  // an accepted item raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // the result strobe comes exactly when busy drops
  a_result_at_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == (!busy && $past(busy)))
    else $error("result strobe not aligned with end of busy");

  // a clear passes through S_EXEC alone before its result strobe
  a_clear_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.req_type == REQ_CLEAR)) |-> ##2 out_valid)
    else $error("clear item result missing");

  // any failed request reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.max_value == '0))
    else $error("nonzero value with failing status");

endmodule

bind sparse_table_range_max stm_chk u_chk (.*);

// File: tb/sv/sparse_table_range_max_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_max_tb
// Self-checking bench for the sparse table range maximum block. A short table
// of directed items comes first, with hand-read results where they are
// obvious. A random run follows that fills the table to full while it queries,
// then mixes queries, appends, clears and unused requests. Each result is
// checked in order against the hand-read one if any, else a behavioral model.
// ----------------------------------------------------------------------------
module sparse_table_range_max_tb;
  import stm_pkg::*;

  localparam int TBL_DEPTH    = MAX_ELEMENTS_DEF;
  localparam int TBL_LEVELS   = LEVELS_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int AFTER_FULL   = 40;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [REQ_W-1:0]   REQ_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN    = 32'h8000_0000;

  typedef struct packed {
    req_t item;
    logic is_typed;
    rsp_t typed_rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_data;
  logic out_valid;
  rsp_t out_data;

  // window maxima, entry [k][s] covers elements s .. s+2^k-1
  logic signed [VALUE_W-1:0] win_max [TBL_LEVELS][TBL_DEPTH];
  int       elem_count = 0;
  rsp_t     pending_rsp[$];
  dir_row_t dir_rows[$];
  rsp_t     oldest_rsp;
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;
  int       burst_left = 0;

  always #6 clk = ~clk;

  sparse_table_range_max i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  function automatic req_t mk_req(input logic [REQ_W-1:0] kind,
                                  input logic [VALUE_W-1:0] val,
                                  input logic [RANGE_W-1:0] rb,
                                  input logic [RANGE_W-1:0] re);
    req_t r;
    r.req_type    = kind;
    r.value       = val;
    r.range_begin = rb;
    r.range_end   = re;
    return r;
  endfunction

  // updates the table copy and returns the result the item should give
  function automatic rsp_t apply_request(input req_t r);
    rsp_t rsp;
    logic signed [VALUE_W-1:0] lo_win;
    logic signed [VALUE_W-1:0] hi_win;
    int n;
    int k;
    int w;
    int len;
    int lg;
    int second;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_CLEAR: elem_count = 0;
      REQ_APPEND: begin
        if (elem_count >= TBL_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          n = elem_count;
          win_max[0][n] = r.value;
          // every level whose window fits gets the window that ends at the new element
          for (k = 1; k < TBL_LEVELS && (1 << k) <= n + 1; k++) begin
            w = 1 << k;
            lo_win = win_max[k-1][n+1-w];
            hi_win = win_max[k-1][n+1-w+w/2];
            win_max[k][n+1-w] = (lo_win > hi_win) ? lo_win : hi_win;
          end
          elem_count = n + 1;
        end
      end
      REQ_QUERY: begin
        if (r.range_begin > r.range_end) begin
          rsp.status = ST_EMPTY;
        end else if (int'(r.range_end) >= elem_count) begin
          rsp.status = ST_RANGE;
        end else begin
          len = int'(r.range_end) - int'(r.range_begin) + 1;
          lg = 0;
          while ((2 << lg) <= len) lg++;
          if (lg > TBL_LEVELS - 1) lg = TBL_LEVELS - 1;
          second = int'(r.range_end) + 1 - (1 << lg);
          lo_win = win_max[lg][r.range_begin];
          hi_win = win_max[lg][second];
          rsp.max_value = (lo_win > hi_win) ? lo_win : hi_win;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '1;
      3: return $urandom_range(0, 31) - 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t make_query();
    int roll;
    int b;
    int e;
    roll = $urandom_range(0, 99);
    if (elem_count > 0 && roll < 8) begin
      b = 0;
      e = elem_count - 1;
    end else if (elem_count > 0 && roll < 80) begin
      b = $urandom_range(0, elem_count - 1);
      if (roll < 40) e = b + $urandom_range(0, 17);
      else e = $urandom_range(b, elem_count - 1);
      if (e > elem_count - 1) e = elem_count - 1;
    end else if (elem_count < TBL_DEPTH && roll < 85) begin
      // ends just past the last filled element
      e = elem_count;
      b = $urandom_range(0, e);
    end else if (roll < 93) begin
      e = $urandom_range(0, TBL_DEPTH - 2);
      b = $urandom_range(e + 1, TBL_DEPTH - 1);
    end else begin
      b = $urandom_range(0, TBL_DEPTH - 1);
      e = $urandom_range(0, TBL_DEPTH - 1);
    end
    return mk_req(REQ_QUERY, pick_value(), b[RANGE_W-1:0], e[RANGE_W-1:0]);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] val,
                         input int rb, input int re, input logic is_typed,
                         input logic [VALUE_W-1:0] max_v,
                         input logic [STATUS_W-1:0] st);
    dir_row_t row;
    row.item                = mk_req(kind, val, rb[RANGE_W-1:0], re[RANGE_W-1:0]);
    row.is_typed            = is_typed;
    row.typed_rsp.max_value = max_v;
    row.typed_rsp.status    = st;
    dir_rows = {dir_rows, row};
  endtask

  task automatic drive_item(input req_t item, input logic is_typed, input rsp_t typed_rsp);
    rsp_t predicted;
    int gap;
    in_data <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = apply_request(item);
    pending_rsp = {pending_rsp, (is_typed ? typed_rsp : predicted)};
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    req_t item;
    logic [REQ_W-1:0] kind;
    logic seen_full;
    int roll;
    int rand_cnt;
    int after_full;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    seen_full  = 1'b0;
    rand_cnt   = 0;
    after_full = 0;

    add_row(REQ_QUERY,  '0,           0,    0, 1'b1, '0,      ST_RANGE);
    add_row(REQ_QUERY,  '0,           5,    3, 1'b1, '0,      ST_EMPTY);
    add_row(REQ_APPEND, VAL_MAX,      0,    0, 1'b1, '0,      ST_OK);
    add_row(REQ_APPEND, VAL_MIN,      0,    0, 1'b1, '0,      ST_OK);
    add_row(REQ_APPEND, '1,           0,    0, 1'b1, '0,      ST_OK);
    add_row(REQ_APPEND, '0,           0,    0, 1'b1, '0,      ST_OK);
    add_row(REQ_APPEND, 32'd1,        0,    0, 1'b1, '0,      ST_OK);
    add_row(REQ_QUERY,  '0,           0,    0, 1'b1, VAL_MAX, ST_OK);
    add_row(REQ_QUERY,  '0,           1,    1, 1'b1, VAL_MIN, ST_OK);
    add_row(REQ_QUERY,  '0,           1,    4, 1'b0, '0,      ST_OK);
    add_row(REQ_QUERY,  '0,           0,    4, 1'b0, '0,      ST_OK);
    add_row(REQ_QUERY,  '0,           2,    3, 1'b0, '0,      ST_OK);
    add_row(REQ_QUERY,  '0,           4,    5, 1'b1, '0,      ST_RANGE);
    add_row(REQ_QUERY,  '0,           1023, 1023, 1'b1, '0,   ST_RANGE);
    // begin above end reports empty, though begin lies past the last element
    add_row(REQ_QUERY,  '0,           1023, 0, 1'b1, '0,      ST_EMPTY);
    add_row(REQ_UNUSED, '1,           1023, 1023, 1'b1, '0,   ST_OK);
    add_row(REQ_APPEND, 32'h5555_5555, 1023, 1023, 1'b1, '0,  ST_OK);
    add_row(REQ_QUERY,  '0,           0,    5, 1'b0, '0,      ST_OK);
    add_row(REQ_CLEAR,  '1,           1023, 1023, 1'b1, '0,   ST_OK);
    add_row(REQ_QUERY,  '0,           0,    0, 1'b1, '0,      ST_RANGE);
    add_row(REQ_APPEND, 32'hAAAA_AAAA, 0,   0, 1'b1, '0,      ST_OK);
    add_row(REQ_APPEND, 32'd7,        0,    0, 1'b1, '0,      ST_OK);
    add_row(REQ_APPEND, VAL_MIN,      0,    0, 1'b1, '0,      ST_OK);
    add_row(REQ_QUERY,  '0,           0,    2, 1'b0, '0,      ST_OK);
    add_row(REQ_QUERY,  '0,           1,    2, 1'b0, '0,      ST_OK);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].is_typed,
                                     dir_rows[i].typed_rsp);

    // fill to full while querying, then work the full table and refills
    while (rand_cnt < RANDOM_ITEMS || after_full < AFTER_FULL) begin
      roll = $urandom_range(0, 99);
      if (!seen_full) begin
        if (roll < 96) kind = REQ_APPEND;
        else if (roll < 99) kind = REQ_QUERY;
        else kind = REQ_UNUSED;
      end else begin
        if (roll < 60) kind = REQ_QUERY;
        else if (roll < 88) kind = REQ_APPEND;
        else if (roll < 94) kind = REQ_CLEAR;
        else kind = REQ_UNUSED;
      end
      if (kind == REQ_QUERY) item = make_query();
      else item = mk_req(kind, pick_value(), RANGE_W'($urandom()), RANGE_W'($urandom()));
      if (elem_count == TBL_DEPTH) seen_full = 1'b1;
      if (seen_full) after_full++;
      drive_item(item, 1'b0, '0);
      if (kind != REQ_UNUSED) rand_cnt++;
    end
    start <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2 * TBL_LEVELS) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no item outstanding: max_value %0d status %0d",
               out_data.max_value, out_data.status);
        mismatch_cnt++;
      end else begin
        oldest_rsp = pending_rsp.pop_front();
        if (out_data.max_value !== oldest_rsp.max_value) begin
          $error("max_value: expected %0d, actual %0d",
                 oldest_rsp.max_value, out_data.max_value);
          mismatch_cnt++;
        end
        if (out_data.status !== oldest_rsp.status) begin
          $error("status: expected %0d, actual %0d", oldest_rsp.status, out_data.status);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
